FILE: design/mstk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mstk_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam int VTX_PORT_W = 6;
   localparam int WGT_PORT_W = 16;
   localparam int COST_W     = 22;
   localparam int VCNT_W     = 7;

   localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

   typedef enum logic [7:0] {
      S_LOAD     = 8'b0000_0001,
      S_SCAN     = 8'b0000_0010,
      S_SCAN_END = 8'b0000_0100,
      S_PICK     = 8'b0000_1000,
      S_FIND_RD  = 8'b0001_0000,
      S_FIND_CHK = 8'b0010_0000,
      S_UNION    = 8'b0100_0000,
      S_FLUSH    = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_step;
      logic pick;
      logic find_chk;
      logic union_go;
      logic flush_go;
   } cmd_type;

   typedef struct packed {
      logic accept_last;
      logic total_zero_next;
      logic scan_last;
      logic root_found;
      logic on_dst;
      logic joins;
      logic pend_vld;
      logic out_busy;
      logic graph_done;
   } status_type;

endpackage
`default_nettype wire

FILE: design/minimum_spanning_tree_kruskal_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake        Payload
// req_      in   valid / stall    src_vertex, dst_vertex, edge_weight, last_edge
// rsp_      out  valid / stall    edge_valid, out_source, out_dest, out_weight,
//                                 running_cost, overflow_flag, last_result
// csr_      in   valid / ready    vertex_count (ready is always high)
//
// Edges load one transaction per cycle into the edge store. After the last edge the
// block stalls req_ and runs the tree: for each stored edge a full pass over the
// store picks the next edge by weight, then the union-find walk reads and checks
// each vertex on each endpoint's path to its root, and the union follows. Reset
// is synchronous and active high; it clears control state only. A stalled
// result holds in the output register and the tree walk waits behind it.
module minimum_spanning_tree_kruskal_top #(
   parameter int MAX_VERTICES = mstk_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = mstk_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = mstk_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [mstk_pkg::VTX_PORT_W-1:0]        req_src_vertex,
   input  wire logic [mstk_pkg::VTX_PORT_W-1:0]        req_dst_vertex,
   input  wire logic signed [mstk_pkg::WGT_PORT_W-1:0] req_edge_weight,
   input  wire logic                                   req_last_edge,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_edge_valid,
   output logic [mstk_pkg::VTX_PORT_W-1:0]             rsp_out_source,
   output logic [mstk_pkg::VTX_PORT_W-1:0]             rsp_out_dest,
   output logic signed [mstk_pkg::WGT_PORT_W-1:0]      rsp_out_weight,
   output logic signed [mstk_pkg::COST_W-1:0]          rsp_running_cost,
   output logic                                        rsp_overflow_flag,
   output logic                                        rsp_last_result,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mstk_pkg::VCNT_W-1:0]            csr_vertex_count
);

   mstk_pkg::cmd_type    cmd;
   mstk_pkg::status_type sts;
   logic [mstk_pkg::VCNT_W-1:0] vcount_ff;

   // vertex count register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= mstk_pkg::VCNT_RESET;
      end else if (csr_valid && csr_ready) begin
         vcount_ff <= csr_vertex_count;
      end
   end

   assign csr_ready = 1'b1;
   // take edges only while loading
   assign req_stall = ~cmd.load;

   mstk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   mstk_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .vcount            (vcount_ff),
      .req_valid         (req_valid),
      .req_src_vertex    (req_src_vertex),
      .req_dst_vertex    (req_dst_vertex),
      .req_edge_weight   (req_edge_weight),
      .req_last_edge     (req_last_edge),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_valid    (rsp_edge_valid),
      .rsp_out_source    (rsp_out_source),
      .rsp_out_dest      (rsp_out_dest),
      .rsp_out_weight    (rsp_out_weight),
      .rsp_running_cost  (rsp_running_cost),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
`default_nettype wire

FILE: design/mstk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mstk_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mstk_pkg::status_type sts,
   output mstk_pkg::cmd_type       cmd
);

   mstk_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mstk_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         mstk_pkg::S_LOAD: begin
            cmd.load = 1'b1;
            if (sts.accept_last) begin
               cmd.start = 1'b1;
               state_in  = sts.total_zero_next ? mstk_pkg::S_FLUSH : mstk_pkg::S_SCAN;
            end
         end
         mstk_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = mstk_pkg::S_SCAN_END;
            end
         end
         mstk_pkg::S_SCAN_END: begin
            state_in = mstk_pkg::S_PICK;
         end
         mstk_pkg::S_PICK: begin
            cmd.pick = 1'b1;
            state_in = mstk_pkg::S_FIND_RD;
         end
         mstk_pkg::S_FIND_RD: begin
            state_in = mstk_pkg::S_FIND_CHK;
         end
         mstk_pkg::S_FIND_CHK: begin
            cmd.find_chk = 1'b1;
            state_in = (sts.root_found && sts.on_dst) ? mstk_pkg::S_UNION
                                                      : mstk_pkg::S_FIND_RD;
         end
         mstk_pkg::S_UNION: begin
            // hold while a joining edge meets an older result that cannot move to the output
            if (!(sts.joins && sts.pend_vld && sts.out_busy)) begin
               cmd.union_go = 1'b1;
               state_in = sts.graph_done ? mstk_pkg::S_FLUSH : mstk_pkg::S_SCAN;
            end
         end
         mstk_pkg::S_FLUSH: begin
            if (!sts.out_busy) begin
               cmd.flush_go = 1'b1;
               state_in = mstk_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = mstk_pkg::S_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/mstk_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mstk_dp #(
   parameter int MAX_VERTICES = mstk_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = mstk_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = mstk_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mstk_pkg::cmd_type                    cmd,
   output mstk_pkg::status_type                      sts,
   input  wire logic [mstk_pkg::VCNT_W-1:0]          vcount,
   input  wire logic                                 req_valid,
   input  wire logic [mstk_pkg::VTX_PORT_W-1:0]      req_src_vertex,
   input  wire logic [mstk_pkg::VTX_PORT_W-1:0]      req_dst_vertex,
   input  wire logic signed [mstk_pkg::WGT_PORT_W-1:0] req_edge_weight,
   input  wire logic                                 req_last_edge,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_edge_valid,
   output logic [mstk_pkg::VTX_PORT_W-1:0]           rsp_out_source,
   output logic [mstk_pkg::VTX_PORT_W-1:0]           rsp_out_dest,
   output logic signed [mstk_pkg::WGT_PORT_W-1:0]    rsp_out_weight,
   output logic signed [mstk_pkg::COST_W-1:0]        rsp_running_cost,
   output logic                                      rsp_overflow_flag,
   output logic                                      rsp_last_result
);

   localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NW  = $clog2(MAX_EDGES + 1);
   localparam int EW  = 2 * VW + WEIGHT_BITS;
   localparam int CW  = mstk_pkg::COST_W;
   localparam int SW  = ((WEIGHT_BITS > CW) ? WEIGHT_BITS : CW) + 1;
   localparam int OWW = mstk_pkg::WGT_PORT_W;
   localparam int PW  = mstk_pkg::VTX_PORT_W;

   // edge store
   logic [EW-1:0] emem [MAX_EDGES];
   logic [NW-1:0] total_ff;
   logic          dropped_ff;

   logic [mstk_pkg::VCNT_W-1:0] vc_eff;
   logic [31:0]                 raw_w;
   logic [WEIGHT_BITS-1:0]      w_in;
   logic                        in_ok, acc, store_ok;

   assign vc_eff   = (vcount > mstk_pkg::VCNT_W'(MAX_VERTICES))
                     ? mstk_pkg::VCNT_W'(MAX_VERTICES) : vcount;
   assign in_ok    = (mstk_pkg::VCNT_W'(req_src_vertex) < vc_eff) &&
                     (mstk_pkg::VCNT_W'(req_dst_vertex) < vc_eff);
   assign acc      = req_valid & cmd.load;
   assign store_ok = in_ok && (total_ff != NW'(MAX_EDGES));
   assign raw_w    = {16'b0, req_edge_weight};
   assign w_in     = raw_w[WEIGHT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (acc && store_ok) begin
         emem[total_ff[AW-1:0]] <= {req_src_vertex[VW-1:0], req_dst_vertex[VW-1:0], w_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.flush_go) begin
         total_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (acc && in_ok) begin
         if (store_ok) begin
            total_ff <= total_ff + NW'(1);
         end else begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // scan for the next edge in (weight, arrival) order
   logic [AW-1:0] idx_ff, ridx_ff;
   logic [EW-1:0] rdata_ff;
   logic          rvld_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= emem[idx_ff];
      ridx_ff  <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= cmd.scan_step;
         if (cmd.start || cmd.union_go) begin
            idx_ff <= '0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + AW'(1);
         end
      end
   end

   logic signed [WEIGHT_BITS-1:0] c_w;
   logic [VW-1:0]                 c_src, c_dst;
   logic signed [WEIGHT_BITS-1:0] best_w_ff, prev_w_ff;
   logic [AW-1:0]                 best_i_ff, prev_i_ff;
   logic [VW-1:0]                 best_src_ff, best_dst_ff;
   logic                          best_vld_ff, has_prev_ff;
   logic                          gt_prev, lt_best;

   assign c_w   = rdata_ff[WEIGHT_BITS-1:0];
   assign c_dst = rdata_ff[WEIGHT_BITS +: VW];
   assign c_src = rdata_ff[WEIGHT_BITS + VW +: VW];
   assign gt_prev = !has_prev_ff || (c_w > prev_w_ff) ||
                    ((c_w == prev_w_ff) && (ridx_ff > prev_i_ff));
   assign lt_best = !best_vld_ff || (c_w < best_w_ff) ||
                    ((c_w == best_w_ff) && (ridx_ff < best_i_ff));

   always_ff @(posedge clock) begin
      if (rvld_ff && gt_prev && lt_best) begin
         best_w_ff   <= c_w;
         best_i_ff   <= ridx_ff;
         best_src_ff <= c_src;
         best_dst_ff <= c_dst;
      end
      if (cmd.pick) begin
         prev_w_ff <= best_w_ff;
         prev_i_ff <= best_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
         has_prev_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            has_prev_ff <= 1'b0;
         end else if (cmd.pick) begin
            has_prev_ff <= 1'b1;
         end
         if (cmd.start || cmd.pick) begin
            best_vld_ff <= 1'b0;
         end else if (rvld_ff && gt_prev && lt_best) begin
            best_vld_ff <= 1'b1;
         end
      end
   end

   // union-find table
   logic [VW-1:0]           pmem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] pvalid_ff;
   logic [VW-1:0]           pm_q_ff, cur_ff, rs_ff, rd_ff;
   logic                    pv_q_ff, on_dst_ff, root_found, joins;

   assign root_found = !pv_q_ff || (pm_q_ff == cur_ff);
   assign joins      = (rs_ff != rd_ff);

   always_ff @(posedge clock) begin
      pm_q_ff <= pmem[cur_ff];
      pv_q_ff <= pvalid_ff[cur_ff];
      if (cmd.union_go && joins) begin
         pmem[rd_ff] <= rs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= '0;
      end else if (cmd.start) begin
         pvalid_ff <= '0;
      end else if (cmd.union_go && joins) begin
         pvalid_ff[rd_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_dst_ff <= 1'b0;
      end else if (cmd.pick) begin
         on_dst_ff <= 1'b0;
      end else if (cmd.find_chk && root_found) begin
         on_dst_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         cur_ff <= best_src_ff;
      end else if (cmd.find_chk) begin
         if (root_found) begin
            if (!on_dst_ff) begin
               rs_ff  <= cur_ff;
               cur_ff <= best_dst_ff;
            end else begin
               rd_ff <= cur_ff;
            end
         end else begin
            cur_ff <= pm_q_ff;
         end
      end
   end

   // cost and counters
   logic signed [CW-1:0] cost_ff, cost_in;
   logic signed [SW-1:0] sum;
   logic [VW-1:0]        acc_cnt_ff;
   logic [NW-1:0]        proc_ff;

   assign sum = SW'(cost_ff) + SW'(best_w_ff);
   always_comb begin
      if (sum[SW-1:CW-1] != {(SW-CW+1){1'b0}} && sum[SW-1:CW-1] != {(SW-CW+1){1'b1}}) begin
         cost_in = sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         cost_in = sum[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff    <= '0;
         acc_cnt_ff <= '0;
         proc_ff    <= '0;
      end else if (cmd.start) begin
         cost_ff    <= '0;
         acc_cnt_ff <= '0;
         proc_ff    <= '0;
      end else if (cmd.union_go) begin
         proc_ff <= proc_ff + NW'(1);
         if (joins) begin
            cost_ff    <= cost_in;
            acc_cnt_ff <= acc_cnt_ff + VW'(1);
         end
      end
   end

   // pending result and output register
   logic                 pend_vld_ff;
   logic [VW-1:0]        pend_src_ff, pend_dst_ff;
   logic signed [OWW-1:0] pend_w_ff;
   logic signed [CW-1:0] pend_cost_ff;
   logic                 out_load, rsp_valid_ff;

   assign out_load = (cmd.union_go && joins && pend_vld_ff) || cmd.flush_go;

   always_ff @(posedge clock) begin
      if (cmd.union_go && joins) begin
         pend_src_ff  <= best_src_ff;
         pend_dst_ff  <= best_dst_ff;
         pend_w_ff    <= OWW'(best_w_ff);
         pend_cost_ff <= cost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (cmd.start || cmd.flush_go) begin
         pend_vld_ff <= 1'b0;
      end else if (cmd.union_go && joins) begin
         pend_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_edge_valid    <= pend_vld_ff;
         rsp_out_source    <= pend_vld_ff ? PW'(pend_src_ff) : '0;
         rsp_out_dest      <= pend_vld_ff ? PW'(pend_dst_ff) : '0;
         rsp_out_weight    <= pend_vld_ff ? pend_w_ff : '0;
         rsp_running_cost  <= pend_vld_ff ? pend_cost_ff : '0;
         rsp_overflow_flag <= dropped_ff;
         rsp_last_result   <= cmd.flush_go;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.accept_last     = acc && req_last_edge;
   assign sts.total_zero_next = (total_ff == '0) && !store_ok;
   assign sts.scan_last       = (idx_ff == AW'(total_ff - NW'(1)));
   assign sts.root_found      = root_found;
   assign sts.on_dst          = on_dst_ff;
   assign sts.joins           = joins;
   assign sts.pend_vld        = pend_vld_ff;
   assign sts.out_busy        = rsp_valid_ff && rsp_stall;
   assign sts.graph_done      = (proc_ff + NW'(1) == total_ff) ||
                                (joins && (acc_cnt_ff == VW'(MAX_VERTICES - 2)));

endmodule
`default_nettype wire
